// ===== design/jog_switch_event_decoder_top_macros.svh =====
// Assertion macros shared by the jog switch event decoder modules.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef JOG_SWITCH_EVENT_DECODER_TOP_MACROS_SVH
`define JOG_SWITCH_EVENT_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define JSED_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define JSED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/jsed_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, button masks and event codes for the jog switch event decoder.
// No dependencies.
package jsed_pkg;

    localparam int unsigned MASK_W = 5;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned EV_W   = 3;

    typedef logic [MASK_W-1:0] mask_t;
    typedef logic [TIME_W-1:0] time_t;
    typedef logic [EV_W-1:0]   event_t;

    localparam mask_t BTN_NONE   = 5'b00000;
    localparam mask_t BTN_UP     = 5'b00001;
    localparam mask_t BTN_DOWN   = 5'b00010;
    localparam mask_t BTN_LEFT   = 5'b00100;
    localparam mask_t BTN_RIGHT  = 5'b01000;
    localparam mask_t BTN_CENTER = 5'b10000;

    localparam event_t EV_NONE  = 3'd0;
    localparam event_t EV_UP    = 3'd1;
    localparam event_t EV_DOWN  = 3'd2;
    localparam event_t EV_LEFT  = 3'd3;
    localparam event_t EV_RIGHT = 3'd4;
    localparam event_t EV_SHORT = 3'd5;
    localparam event_t EV_LONG  = 3'd6;

    // Register indexes on the configuration port
    localparam logic REG_DEBOUNCE   = 1'b0;
    localparam logic REG_LONG_PRESS = 1'b1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd20;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] long_press_time;
    } cfg_t;

    function automatic logic two_or_more(input mask_t m);
        return (m != BTN_NONE) && ((m & (m - mask_t'(1))) != BTN_NONE);
    endfunction

    function automatic event_t dir_code(input mask_t m);
        event_t code;
        case (m)
            BTN_UP:    code = EV_UP;
            BTN_DOWN:  code = EV_DOWN;
            BTN_LEFT:  code = EV_LEFT;
            BTN_RIGHT: code = EV_RIGHT;
            default:   code = EV_NONE;
        endcase
        return code;
    endfunction

endpackage

// ===== design/jsed_apb_regs.sv =====
`timescale 1ns / 1ps
// APB-style register file holding the debounce and long-press thresholds.
// Depends on jsed_pkg.
module jsed_apb_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output jsed_pkg::cfg_t    cfg
);
    import jsed_pkg::*;

    logic [CFG_W-1:0] debounce_reg;
    logic [CFG_W-1:0] long_press_reg;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    // Byte lanes below the word are ignored
    assign reg_sel = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_DEBOUNCE:   debounce_reg   <= pwdata[CFG_W-1:0];
                REG_LONG_PRESS: long_press_reg <= pwdata[CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_DEBOUNCE:   prdata = {16'd0, debounce_reg};
            REG_LONG_PRESS: prdata = {16'd0, long_press_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg.debounce_time   = debounce_reg;
    assign cfg.long_press_time = long_press_reg;

endmodule

// ===== design/jsed_decode.sv =====
`timescale 1ns / 1ps
// Debounce and event decision for one sample, with the switch state registers.
// Depends on jsed_pkg and the assertion macro header.
`include "jog_switch_event_decoder_top_macros.svh"
module jsed_decode (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  jsed_pkg::mask_t   mask,
    input  jsed_pkg::time_t   now,
    input  jsed_pkg::cfg_t    cfg,
    output jsed_pkg::event_t  event_code
);
    import jsed_pkg::*;

    mask_t cand_reg,   cand_next;
    mask_t stable_reg, stable_next;
    time_t cand_start_reg, cand_start_next;
    time_t center_time_reg, center_time_next;
    logic  lock_reg, lock_next;
    logic  long_done_reg, long_done_next;

    time_t cand_elapsed;
    time_t center_elapsed;
    logic  debounce_ok;
    logic  long_ok;

    assign cand_elapsed   = now - cand_start_reg;
    assign center_elapsed = now - center_time_reg;
    assign debounce_ok    = cand_elapsed >= {16'd0, cfg.debounce_time};
    assign long_ok        = center_elapsed >= {16'd0, cfg.long_press_time};

    always_comb begin
        cand_next        = cand_reg;
        stable_next      = stable_reg;
        cand_start_next  = cand_start_reg;
        center_time_next = center_time_reg;
        lock_next        = lock_reg;
        long_done_next   = long_done_reg;
        event_code       = EV_NONE;

        if (mask != cand_reg) begin
            // restart the debounce window
            cand_next       = mask;
            cand_start_next = now;
        end else if (cand_reg != stable_reg && debounce_ok) begin
            stable_next = cand_reg;
            if (two_or_more(cand_reg) || (stable_reg != BTN_NONE && cand_reg != BTN_NONE)) begin
                lock_next      = 1'b1;
                long_done_next = 1'b0;
            end else if (lock_reg) begin
                if (cand_reg == BTN_NONE) begin
                    lock_next = 1'b0;
                end
            end else if (cand_reg == BTN_CENTER) begin
                center_time_next = now;
                long_done_next   = 1'b0;
            end else if (cand_reg == BTN_NONE) begin
                if (stable_reg == BTN_CENTER && !long_done_reg) begin
                    event_code = EV_SHORT;
                end
            end else begin
                event_code = dir_code(cand_reg);
            end
        end else if (!lock_reg && stable_reg == BTN_CENTER && !long_done_reg && long_ok) begin
            long_done_next = 1'b1;
            event_code     = EV_LONG;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg        <= BTN_NONE;
            stable_reg      <= BTN_NONE;
            cand_start_reg  <= '0;
            center_time_reg <= '0;
            lock_reg        <= 1'b0;
            long_done_reg   <= 1'b0;
        end else if (step_en) begin
            cand_reg        <= cand_next;
            stable_reg      <= stable_next;
            cand_start_reg  <= cand_start_next;
            center_time_reg <= center_time_next;
            lock_reg        <= lock_next;
            long_done_reg   <= long_done_next;
        end
    end

    `JSED_ASSERT_NOW(a_chord_locks, two_or_more(stable_reg), lock_reg,
                     "chord stable without lock")
    `JSED_ASSERT_NOW(a_lock_silent, lock_reg, event_code == EV_NONE, "event while locked")
    `JSED_ASSERT_NEXT(a_long_once, step_en && event_code == EV_LONG,
                      long_done_reg && stable_reg == BTN_CENTER, "long press not recorded")

endmodule

// ===== design/jog_switch_event_decoder_top.sv =====
`timescale 1ns / 1ps
// Top level of the jog switch event decoder: sample register, decoder, result register.
// Depends on jsed_pkg, jsed_apb_regs, jsed_decode and the assertion macro header.
//
// One sample of the five-way switch goes in per beat and exactly one event beat comes
// out for it, in order. The block takes one sample every cycle when the result side
// keeps up; a sample passes the sample register, then the result register. The rate
// is set by the single decode step between them, which reads and updates the debounce
// and press state together, so the next sample always sees the last one's state. The
// result register sits between the sides: while an event waits, one more sample can be
// registered. The user writes thresholds over the APB port (debounce time at 0x0,
// long-press time at 0x4, low 16 bits) only while idle; the block does not enforce it.
`include "jog_switch_event_decoder_top_macros.svh"
module jog_switch_event_decoder_top (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // sample channel
    input  logic              s_valid,
    output logic              s_ready,
    input  jsed_pkg::mask_t   s_pressed_mask,
    input  jsed_pkg::time_t   s_now_ms,
    // event channel
    output logic              m_valid,
    input  logic              m_ready,
    output jsed_pkg::event_t  m_event_code
);
    import jsed_pkg::*;

    cfg_t   cfg;
    logic   in_valid_reg;
    mask_t  in_mask_reg;
    time_t  in_now_reg;
    logic   out_valid_reg;
    event_t out_event_reg;
    event_t step_event;
    logic   advance;

    // Move the registered sample through the decoder when the result slot is free or being taken
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    // Take a new sample whenever the sample register is empty or empties this cycle
    assign s_ready = !in_valid_reg || advance;

    jsed_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    jsed_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .mask       (in_mask_reg),
        .now        (in_now_reg),
        .cfg        (cfg),
        .event_code (step_event)
    );

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: hold until the slot advances
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_mask_reg <= s_pressed_mask;
            in_now_reg  <= s_now_ms;
        end
        if (advance) begin
            out_event_reg <= step_event;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_event_code = out_event_reg;

    `JSED_ASSERT_NOW(a_stall_full, !s_ready, in_valid_reg && out_valid_reg && !m_ready,
                     "sample stalled with room")
    `JSED_ASSERT_NOW(a_code_range, m_valid, m_event_code <= EV_LONG, "event code out of range")
    `JSED_ASSERT_NEXT(a_advance_fills, advance, m_valid, "advanced sample lost")

endmodule
